/* rtl/mls_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix line sums package
// Shared widths, result and register codes, and the column store request.
// ----------------------------------------------------------------------------
package mls_pkg;

  // Field and accumulator widths
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned IN_W      = 32;

  // Parameter defaults
  localparam int unsigned DEF_MAX_COLS      = 32;
  localparam int unsigned DEF_MAX_ROWS      = 32;
  localparam int unsigned DEF_ELEMENT_WIDTH = 32;

  // Largest line count the line index can address
  localparam int unsigned LINE_LIMIT = 32;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ROW  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MAIN = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ANTI = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;

  // Request from the sequencer to the column store
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [SUM_W-1:0] wr_data;
    logic             clear;
  } col_req_t;

  // Map a count register onto 1..limit
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] limit);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > limit) begin
      r = limit;
    end
    return r;
  endfunction

endpackage

/* rtl/matrix_line_sums_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix line sums core
// Row, column and diagonal sums of a matrix streamed in row-major order.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                 Payload
// in       sink       in_valid_i / in_stall_o   element_i
// out      source     out_valid_o / out_stall_i sum_kind_o, line_index_o,
//                                               line_sum_o, last_o
// cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// For each element, one shared 40-bit adder updates the column, row, main
// and anti sums in turn, after a registered column store read.
// A row end adds a step to load the row sum; a matrix end reads, then loads,
// each column (one store read port), then the diagonals of a square matrix.
// Reset, and any configuration write to a listed register, clears all sums.
// A stalled result holds the sequencer only where it must load the next one.
// ----------------------------------------------------------------------------
module matrix_line_sums_core import mls_pkg::*; #(
  parameter int unsigned MAX_COLS      = DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS      = DEF_MAX_ROWS,
  parameter int unsigned ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Element channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [IN_W-1:0]      element_i,
  // Result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [KIND_W-1:0]    sum_kind_o,
  output logic [IDX_W-1:0]     line_index_o,
  output logic [SUM_W-1:0]     line_sum_o,
  output logic                 last_o,
  // Configuration channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]     cfg_data_i
);

  localparam int unsigned COL_LIM = (MAX_COLS < LINE_LIMIT) ? MAX_COLS : LINE_LIMIT;
  localparam int unsigned ROW_LIM = (MAX_ROWS < LINE_LIMIT) ? MAX_ROWS : LINE_LIMIT;

  // Sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_COL    = 4'd1;
  localparam logic [3:0] ST_ROW    = 4'd2;
  localparam logic [3:0] ST_MAIN   = 4'd3;
  localparam logic [3:0] ST_ANTI   = 4'd4;
  localparam logic [3:0] ST_ROWOUT = 4'd5;
  localparam logic [3:0] ST_RD     = 4'd6;
  localparam logic [3:0] ST_COLOUT = 4'd7;
  localparam logic [3:0] ST_DMAIN  = 4'd8;
  localparam logic [3:0] ST_DANTI  = 4'd9;

  logic [3:0]        state_q, state_d;
  logic [CNT_W-1:0]  row_cnt_q, row_cnt_d;
  logic [CNT_W-1:0]  col_cnt_q, col_cnt_d;
  logic [IDX_W-1:0]  row_pos_q, row_pos_d;
  logic [IDX_W-1:0]  col_pos_q, col_pos_d;
  logic [SUM_W-1:0]  row_sum_q, row_sum_d;
  logic [SUM_W-1:0]  main_q, main_d;
  logic [SUM_W-1:0]  anti_q, anti_d;
  logic [SUM_W-1:0]  elem_q, elem_d;

  logic              out_valid_q;
  logic [KIND_W-1:0] out_kind_q, out_kind_d;
  logic [IDX_W-1:0]  out_idx_q, out_idx_d;
  logic [SUM_W-1:0]  out_sum_q, out_sum_d;
  logic              out_last_q, out_last_d;
  logic              out_load;
  logic              out_free;

  logic [CNT_W-1:0]  rows_eff, cols_eff;
  logic              square;
  logic              row_end, mat_end, col_end;
  logic              main_hit, anti_hit;
  logic              in_fire, cfg_fire, clear_all;
  logic [SUM_W-1:0]  elem_ext;
  logic [SUM_W-1:0]  acc_a, acc_sum;
  logic [SUM_W-1:0]  col_rd_data;
  col_req_t          col_req;

  // Column sum store
  mls_colstore #(
    .DEPTH (COL_LIM)
  ) u_colstore (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (col_req),
    .rd_data_o (col_rd_data)
  );

  // Effective geometry
  assign rows_eff = clamp_count(row_cnt_q, CNT_W'(ROW_LIM));
  assign cols_eff = clamp_count(col_cnt_q, CNT_W'(COL_LIM));
  assign square   = (rows_eff == cols_eff);
  assign col_end  = ({1'b0, col_pos_q} == (cols_eff - CNT_W'(1)));
  assign row_end  = ({1'b0, row_pos_q} == (rows_eff - CNT_W'(1)));
  assign mat_end  = row_end;
  assign main_hit = square && (row_pos_q == col_pos_q);
  assign anti_hit = square &&
                    (({1'b0, row_pos_q} + {1'b0, col_pos_q}) == (rows_eff - CNT_W'(1)));

  // Sign-extend the element's low bits
  assign elem_ext = {{(SUM_W - ELEMENT_WIDTH){element_i[ELEMENT_WIDTH-1]}},
                     element_i[ELEMENT_WIDTH-1:0]};

  // Handshakes
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Shared adder: pick the accumulator for this step
  always_comb begin
    unique case (state_q)
      ST_COL:  acc_a = col_rd_data;
      ST_ROW:  acc_a = row_sum_q;
      ST_MAIN: acc_a = main_q;
      ST_ANTI: acc_a = anti_q;
      default: acc_a = '0;
    endcase
  end

  assign acc_sum = acc_a + elem_q;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    row_cnt_d  = row_cnt_q;
    col_cnt_d  = col_cnt_q;
    row_pos_d  = row_pos_q;
    col_pos_d  = col_pos_q;
    row_sum_d  = row_sum_q;
    main_d     = main_q;
    anti_d     = anti_q;
    elem_d     = elem_q;
    col_req    = '0;
    out_load   = 1'b0;
    out_kind_d = KIND_ROW;
    out_idx_d  = '0;
    out_sum_d  = '0;
    out_last_d = 1'b0;
    clear_all  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        // Take register writes; a listed register starts a new matrix
        if (cfg_fire) begin
          if (cfg_index_i == CFG_ROW_COUNT) begin
            row_cnt_d = cfg_data_i;
            clear_all = 1'b1;
          end else if (cfg_index_i == CFG_COL_COUNT) begin
            col_cnt_d = cfg_data_i;
            clear_all = 1'b1;
          end
        end
        // Latch the element and fetch its column sum
        if (in_fire) begin
          elem_d          = elem_ext;
          col_req.rd_en   = 1'b1;
          col_req.rd_addr = col_pos_q;
          state_d         = ST_COL;
        end
      end
      ST_COL: begin
        col_req.wr_en   = 1'b1;
        col_req.wr_addr = col_pos_q;
        col_req.wr_data = acc_sum;
        state_d         = ST_ROW;
      end
      ST_ROW: begin
        row_sum_d = acc_sum;
        state_d   = ST_MAIN;
      end
      ST_MAIN: begin
        if (main_hit) begin
          main_d = acc_sum;
        end
        state_d = ST_ANTI;
      end
      ST_ANTI: begin
        if (anti_hit) begin
          anti_d = acc_sum;
        end
        if (col_end) begin
          state_d = ST_ROWOUT;
        end else begin
          col_pos_d = col_pos_q + IDX_W'(1);
          state_d   = ST_IDLE;
        end
      end
      ST_ROWOUT: begin
        // Emit the row sum; it is the only result unless the matrix ends
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KIND_ROW;
          out_idx_d  = row_pos_q;
          out_sum_d  = row_sum_q;
          out_last_d = !mat_end;
          row_sum_d  = '0;
          col_pos_d  = '0;
          if (mat_end) begin
            state_d = ST_RD;
          end else begin
            row_pos_d = row_pos_q + IDX_W'(1);
            state_d   = ST_IDLE;
          end
        end
      end
      ST_RD: begin
        // Column position doubles as the drain index
        col_req.rd_en   = 1'b1;
        col_req.rd_addr = col_pos_q;
        state_d         = ST_COLOUT;
      end
      ST_COLOUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KIND_COL;
          out_idx_d  = col_pos_q;
          out_sum_d  = col_rd_data;
          out_last_d = col_end && !square;
          if (!col_end) begin
            col_pos_d = col_pos_q + IDX_W'(1);
            state_d   = ST_RD;
          end else if (square) begin
            state_d = ST_DMAIN;
          end else begin
            clear_all = 1'b1;
            state_d   = ST_IDLE;
          end
        end
      end
      ST_DMAIN: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KIND_MAIN;
          out_sum_d  = main_q;
          state_d    = ST_DANTI;
        end
      end
      ST_DANTI: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KIND_ANTI;
          out_sum_d  = anti_q;
          out_last_d = 1'b1;
          clear_all  = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Clear accumulators and positions for the next matrix
    if (clear_all) begin
      row_sum_d     = '0;
      main_d        = '0;
      anti_d        = '0;
      row_pos_d     = '0;
      col_pos_d     = '0;
      col_req.clear = 1'b1;
    end
  end

  // Control and accumulator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      row_cnt_q <= CNT_W'(1);
      col_cnt_q <= CNT_W'(1);
      row_pos_q <= '0;
      col_pos_q <= '0;
      row_sum_q <= '0;
      main_q    <= '0;
      anti_q    <= '0;
    end else begin
      state_q   <= state_d;
      row_cnt_q <= row_cnt_d;
      col_cnt_q <= col_cnt_d;
      row_pos_q <= row_pos_d;
      col_pos_q <= col_pos_d;
      row_sum_q <= row_sum_d;
      main_q    <= main_d;
      anti_q    <= anti_d;
    end
  end

  // Element holding register
  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
  end

  // Output register: hold while stalled, drop once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_idx_q  <= out_idx_d;
      out_sum_q  <= out_sum_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sum_kind_o   = out_kind_q;
  assign line_index_o = out_idx_q;
  assign line_sum_o   = out_sum_q;
  assign last_o       = out_last_q;

`ifndef SYNTHESIS
  // Positions stay inside the configured matrix while waiting for an element
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (({1'b0, col_pos_q} < cols_eff) &&
                              ({1'b0, row_pos_q} < rows_eff)))
    else $error("position outside the configured matrix");

  // An accepted element goes straight to the column update
  a_accept_to_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_COL))
    else $error("accepted element did not start the column update");

  // Diagonal results carry line index zero
  a_diag_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((sum_kind_o == KIND_MAIN) || (sum_kind_o == KIND_ANTI)))
      |-> (line_index_o == '0))
    else $error("diagonal result with non-zero line index");

  // A result is never overwritten while stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result loaded over a stalled result");

  // The anti diagonal is always the final result of its matrix
  a_anti_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (sum_kind_o == KIND_ANTI)) |-> last_o)
    else $error("anti diagonal result not marked last");
`endif

endmodule

/* rtl/mls_colstore.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix line sums column store
// Column sum memory with one read and one write port, a registered read
// and per-entry valid bits; an entry that is not valid reads as zero.
// ----------------------------------------------------------------------------
module mls_colstore import mls_pkg::*; #(
  parameter int unsigned DEPTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  col_req_t         req_i,
  output logic [SUM_W-1:0] rd_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SUM_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [SUM_W-1:0] rd_q;
  logic             rd_vld_q;

  // Store written column sums
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr[AW-1:0]] <= req_i.wr_data;
    end
  end

  // Track written entries, drop all on clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.clear) begin
      vld_q <= '0;
    end else if (req_i.wr_en) begin
      vld_q[req_i.wr_addr[AW-1:0]] <= 1'b1;
    end
  end

  // Registered read, hold between reads
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (req_i.rd_en) begin
      rd_vld_q <= vld_q[req_i.rd_addr[AW-1:0]];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule
